[rtl/sag_pkg.sv]
// sag_pkg: shared types and constants for the speech activity gate
// depends on nothing; used by the interface users, the accumulator and the top level

package sag_pkg;

    // field widths fixed by the item formats
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 16;
    localparam int LOUD_W     = 14;
    localparam int SUM_W      = 18;
    localparam int OUT_Q_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [LOUD_W-1:0] LOUD_MAX = '1;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOISE_LEVEL      = 2'd0,
        REG_CHANGE_THRESHOLD = 2'd1,
        REG_SIGNAL_COUNT_MIN = 2'd2,
        REG_QUEUE_LIMIT      = 2'd3
    } cfg_reg_t;

    // register reset values
    localparam logic [15:0] NOISE_LEVEL_RST      = 16'd3000;
    localparam logic [7:0]  CHANGE_THRESHOLD_RST = 8'd10;
    localparam logic [13:0] SIGNAL_COUNT_MIN_RST = 14'd20;
    localparam logic [8:0]  QUEUE_LIMIT_RST      = 9'd300;

    // input item
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_buffer;
    } sag_in_t;

    // result item, one per buffer
    typedef struct packed {
        logic [15:0]        peak;
        logic               buffer_has_signal;
        logic               in_speech;
        logic [OUT_Q_W-1:0] queued_buffers;
        logic               segment_ready;
        logic               segment_forced;
        logic [OUT_Q_W-1:0] segment_buffers;
        logic [CNT_W-1:0]   buffer_samples;
    } sag_out_t;

    // per-buffer statistics handed from the accumulator to the decision logic
    typedef struct packed {
        logic [15:0]       peak;
        logic [LOUD_W-1:0] loud_count;
        logic [CNT_W-1:0]  samples;
    } buf_stats_t;

endpackage

[rtl/sag_stream_if.sv]
// sag_stream_if: valid/ready stream channel carrying one item per handshake
// depends on nothing; the item type is given at instantiation

interface sag_stream_if #(parameter type item_t = logic) ();
    logic  valid;
    logic  ready;
    item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

[rtl/sag_buf_acc.sv]
// sag_buf_acc: per-sample accumulation of peak sum, loud count and sample count
// depends on sag_pkg

module sag_buf_acc import sag_pkg::*;
#(
    parameter int DECIMATION = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last,
    input  logic [15:0]                noise_level,
    output buf_stats_t                 stats
);

    localparam int PH_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(DECIMATION - 1);

    logic [CNT_W-1:0]  pos_reg,   pos_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [LOUD_W-1:0] loud_reg,  loud_next;
    logic [SUM_W-1:0]  sum_reg,   sum_next;

    logic [15:0]       mag;
    logic [CNT_W-1:0]  pos_upd;
    logic [PH_W-1:0]   phase_upd;
    logic [LOUD_W-1:0] loud_upd;
    logic [SUM_W-1:0]  sum_upd;
    logic              pos_open;

    // magnitude; the most negative sample gives 32768
    assign mag = sample[SAMPLE_W-1] ? (~sample + 16'd1) : sample;

    always_comb
    begin
        pos_open  = (pos_reg != CNT_MAX);
        // only the first four samples feed the peak
        sum_upd   = (pos_reg < CNT_W'(4)) ? (sum_reg + SUM_W'(mag)) : sum_reg;
        // decimated loudness test, stopped once the position saturates
        loud_upd  = loud_reg;
        if (pos_open && (phase_reg == '0) && (mag > noise_level) && (loud_reg != LOUD_MAX))
        begin
            loud_upd = loud_reg + LOUD_W'(1);
        end
        pos_upd   = pos_open ? (pos_reg + CNT_W'(1)) : pos_reg;
        phase_upd = (phase_reg == PH_LAST) ? '0 : (phase_reg + PH_W'(1));

        stats.peak       = sum_upd[SUM_W-1:2];
        stats.loud_count = loud_upd;
        stats.samples    = pos_upd;

        // hold, advance, or restart at the end of the buffer
        pos_next   = pos_reg;
        phase_next = phase_reg;
        loud_next  = loud_reg;
        sum_next   = sum_reg;
        if (fire)
        begin
            if (last)
            begin
                pos_next   = '0;
                phase_next = '0;
                loud_next  = '0;
                sum_next   = '0;
            end
            else
            begin
                pos_next   = pos_upd;
                phase_next = phase_upd;
                loud_next  = loud_upd;
                sum_next   = sum_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= '0;
            loud_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            loud_reg  <= loud_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

[rtl/speech_activity_gate.sv]
// speech_activity_gate: energy based voice activity gate with hysteresis
// depends on sag_pkg, sag_stream_if and sag_buf_acc
//
// Usage:
//   samples: sink channel of sag_in_t items, one audio sample each, with a
//   last-in-buffer mark. results: source channel of sag_out_t items, one per
//   buffer, produced from the buffer's last sample. cfg_we/cfg_index/cfg_data
//   write the four registers; write them only while no item is in flight.
//   Throughput is one sample per cycle while no buffer end waits in the
//   input register. A sample is taken into an input register, processed
//   from there by the accumulator and decision logic, and its result lands
//   in the output register.
//   When results stalls, the output register holds its item; samples that end
//   no buffer still flow, and a second buffer end waits in the input register,
//   which drops samples.ready until the output register frees.
//   Reset clears all counters, the speech flag and the queue count, sets the
//   registers to their defaults and empties both pipeline registers.

module speech_activity_gate import sag_pkg::*;
#(
    parameter int QUEUE_BITS  = 9,
    parameter int TRIM_MARGIN = 4,
    parameter int DECIMATION  = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sag_stream_if.sink            samples,
    sag_stream_if.source          results
);

    localparam int CMP_W = (QUEUE_BITS > 10) ? QUEUE_BITS + 1 : 11;
    localparam logic [QUEUE_BITS-1:0] QMAX = '1;

    // configuration registers
    logic [15:0] noise_level_reg;
    logic [7:0]  change_threshold_reg;
    logic [13:0] signal_count_min_reg;
    logic [8:0]  queue_limit_reg;

    // buffer level state
    logic                  speech_flag_reg,  speech_flag_next;
    logic [CNT_W-1:0]      noise_cnt_reg,    noise_cnt_next;
    logic [CNT_W-1:0]      signal_cnt_reg,   signal_cnt_next;
    logic [QUEUE_BITS-1:0] queue_count_reg,  queue_count_next;

    // pipeline registers
    logic     s1_valid_reg, s1_valid_next;
    sag_in_t  s1_item_reg;
    logic     out_valid_reg, out_valid_next;
    sag_out_t out_item_reg, out_item_next;

    logic       out_free;
    logic       s1_go;
    logic       buf_end;
    buf_stats_t stats;

    logic                  sig;
    logic [QUEUE_BITS-1:0] q_inc;
    logic [CMP_W-1:0]      keep;
    logic                  seg_ready;
    logic                  seg_forced;
    logic [QUEUE_BITS-1:0] seg_len;

    // handshake
    assign out_free      = !out_valid_reg || results.ready;
    assign s1_go         = s1_valid_reg && (!s1_item_reg.last_in_buffer || out_free);
    assign buf_end       = s1_go && s1_item_reg.last_in_buffer;
    assign samples.ready = !s1_valid_reg || s1_go;
    assign results.valid = out_valid_reg;
    assign results.item  = out_item_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_level_reg      <= NOISE_LEVEL_RST;
            change_threshold_reg <= CHANGE_THRESHOLD_RST;
            signal_count_min_reg <= SIGNAL_COUNT_MIN_RST;
            queue_limit_reg      <= QUEUE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NOISE_LEVEL:      noise_level_reg      <= cfg_data;
                REG_CHANGE_THRESHOLD: change_threshold_reg <= cfg_data[7:0];
                REG_SIGNAL_COUNT_MIN: signal_count_min_reg <= cfg_data[13:0];
                REG_QUEUE_LIMIT:      queue_limit_reg      <= cfg_data[8:0];
                default:              noise_level_reg      <= noise_level_reg;
            endcase
        end
    end

    // per-sample accumulation
    sag_buf_acc #(
        .DECIMATION (DECIMATION)
    ) u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_go),
        .sample      (s1_item_reg.sample),
        .last        (s1_item_reg.last_in_buffer),
        .noise_level (noise_level_reg),
        .stats       (stats)
    );

    // buffer decision: hysteresis, queue trim and segment report
    always_comb
    begin
        sig              = (stats.loud_count >= signal_count_min_reg);
        speech_flag_next = speech_flag_reg;
        noise_cnt_next   = noise_cnt_reg;
        signal_cnt_next  = signal_cnt_reg;
        seg_ready        = 1'b0;
        seg_forced       = 1'b0;
        seg_len          = '0;
        keep             = CMP_W'(change_threshold_reg) + CMP_W'(TRIM_MARGIN);
        q_inc            = (queue_count_reg == QMAX) ? queue_count_reg
                                                     : queue_count_reg + QUEUE_BITS'(1);
        queue_count_next = q_inc;

        if (sig)
        begin
            signal_cnt_next = (signal_cnt_reg == CNT_MAX) ? signal_cnt_reg
                                                          : signal_cnt_reg + CNT_W'(1);
        end
        else
        begin
            noise_cnt_next = (noise_cnt_reg == CNT_MAX) ? noise_cnt_reg
                                                        : noise_cnt_reg + CNT_W'(1);
        end

        if (speech_flag_reg)
        begin
            // speech end; a lone queued buffer gives no segment
            if (noise_cnt_next > CNT_W'(change_threshold_reg))
            begin
                signal_cnt_next  = '0;
                speech_flag_next = 1'b0;
                if (q_inc > QUEUE_BITS'(1))
                begin
                    seg_ready        = 1'b1;
                    seg_len          = q_inc;
                    queue_count_next = '0;
                end
            end
        end
        else
        begin
            if (signal_cnt_next > CNT_W'(change_threshold_reg))
            begin
                noise_cnt_next   = '0;
                speech_flag_next = 1'b1;
            end
            // idle trim, also in the step where speech starts
            if (CMP_W'(q_inc) > keep)
            begin
                queue_count_next = QUEUE_BITS'(keep);
            end
        end

        // queue overflow forces a segment out
        if (CMP_W'(queue_count_next) > CMP_W'(queue_limit_reg))
        begin
            seg_ready        = 1'b1;
            seg_forced       = 1'b1;
            seg_len          = queue_count_next;
            queue_count_next = '0;
        end

        out_item_next.peak              = stats.peak;
        out_item_next.buffer_has_signal = sig;
        out_item_next.in_speech         = speech_flag_next;
        out_item_next.queued_buffers    = OUT_Q_W'(queue_count_next);
        out_item_next.segment_ready     = seg_ready;
        out_item_next.segment_forced    = seg_forced;
        out_item_next.segment_buffers   = OUT_Q_W'(seg_len);
        out_item_next.buffer_samples    = stats.samples;
    end

    // pipeline valid bits
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (samples.ready)
        begin
            s1_valid_next = samples.valid;
        end
        out_valid_next = out_valid_reg;
        if (buf_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            speech_flag_reg <= 1'b0;
            noise_cnt_reg   <= '0;
            signal_cnt_reg  <= '0;
            queue_count_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (buf_end)
            begin
                speech_flag_reg <= speech_flag_next;
                noise_cnt_reg   <= noise_cnt_next;
                signal_cnt_reg  <= signal_cnt_next;
                queue_count_reg <= queue_count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_item_reg <= samples.item;
        end
        if (buf_end)
        begin
            out_item_reg <= out_item_next;
        end
    end

`ifndef ASSERT_OFF
    // a buffer end waiting behind a full, stalled output stays put
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_item_reg.last_in_buffer && out_valid_reg && !results.ready)
        |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("buffer end lost while output stalled");

    // no segment means no segment fields
    a_no_seg_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.segment_ready)
        |-> (!out_item_reg.segment_forced && (out_item_reg.segment_buffers == '0)))
        else $error("segment fields set without a segment");

    // a forced segment empties the queue
    a_forced_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.segment_forced)
        |-> (out_item_reg.queued_buffers == '0))
        else $error("queue not emptied by forced segment");
`endif

endmodule
